>>> sv/cldf_pkg.sv
`timescale 1ns / 1ps

package cldf_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int MAXB_W          = 31;
    localparam logic [MAXB_W-1:0] MAXB_RESET = MAXB_W'(16 * 1024 * 1024);

    // result kinds
    localparam logic [1:0] KIND_BODY  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NO_COLON   = 2'd0;
    localparam logic [1:0] ERR_BAD_LENGTH = 2'd1;
    localparam logic [1:0] ERR_NO_LENGTH  = 2'd2;
    localparam logic [1:0] ERR_BAD_UTF8   = 2'd3;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam logic [3:0] KEY_LEN     = 4'd14;
    localparam logic [3:0] KEY_POS_MAX = 4'd15;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [1:0] code;
    } cldf_result_t;

    // lower-case content-length key
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h6C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> sv/cldf_in_stage.sv
`timescale 1ns / 1ps

module cldf_in_stage
    import cldf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

>>> sv/cldf_core.sv
`timescale 1ns / 1ps

module cldf_core
    import cldf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        b,
    input  logic [MAXB_W-1:0] max_body,
    output logic              res_valid,
    output cldf_result_t      res
);

    localparam int CW = (LENGTH_BITS > MAXB_W) ? LENGTH_BITS : MAXB_W;
    localparam int AW = LENGTH_BITS + 4;

    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_BODY   = 2'b10
    } phase_t;

    typedef enum logic [3:0] {
        STG_WS     = 4'b0001,
        STG_SIGN   = 4'b0010,
        STG_DIGITS = 4'b0100,
        STG_DONE   = 4'b1000
    } num_stage_t;

    // allowed range of the second byte of a multibyte sequence
    localparam logic [2:0] RULE_ANY   = 3'd0;
    localparam logic [2:0] RULE_A0_BF = 3'd1;
    localparam logic [2:0] RULE_80_9F = 3'd2;
    localparam logic [2:0] RULE_90_BF = 3'd3;
    localparam logic [2:0] RULE_80_8F = 3'd4;

    phase_t                 phase_reg, phase_next;
    logic                   fresh_reg, fresh_next;
    logic                   ends_reg, ends_next;
    logic                   colon_reg, colon_next;
    logic [3:0]             key_pos_reg, key_pos_next;
    logic                   key_diff_reg, key_diff_next;
    num_stage_t             stage_reg, stage_next;
    logic                   neg_reg, neg_next;
    logic [LENGTH_BITS-1:0] value_reg, value_next;
    logic                   bad_reg, bad_next;
    logic [1:0]             pend_reg, pend_next;
    logic [2:0]             rule_reg, rule_next;
    logic                   known_reg, known_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;

    logic                   do_clear;
    logic                   do_restart;
    logic [7:0]             lo;
    logic [7:0]             hi;
    logic [7:0]             lower_b;
    logic                   is_digit;
    logic                   is_space;
    logic [AW-1:0]          value_ext;
    logic [AW-1:0]          acc;
    logic                   acc_sat;
    logic                   rem_le1;
    logic                   len_bad;

    assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign is_space  = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) ||
                       (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
    assign lower_b   = ((b >= CHAR_UP_A) && (b <= CHAR_UP_Z)) ? b + CASE_DIFF : b;

    // value * 10 + digit, saturating when it spills past LENGTH_BITS
    assign value_ext = AW'(value_reg);
    assign acc       = (value_ext << 3) + (value_ext << 1) + AW'(b - CHAR_ZERO);
    assign acc_sat   = |acc[AW-1:LENGTH_BITS];

    assign rem_le1   = (rem_reg[LENGTH_BITS-1:1] == '0);
    assign len_bad   = (&value_reg) || (neg_reg && (value_reg != '0)) ||
                       (CW'(value_reg) > CW'(max_body));

    always_comb
    begin
        lo = 8'h80;
        hi = 8'hBF;
        case (rule_reg)
            RULE_A0_BF: lo = 8'hA0;
            RULE_80_9F: hi = 8'h9F;
            RULE_90_BF: lo = 8'h90;
            RULE_80_8F: hi = 8'h8F;
            default:    lo = 8'h80;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        fresh_next    = fresh_reg;
        ends_next     = ends_reg;
        colon_next    = colon_reg;
        key_pos_next  = key_pos_reg;
        key_diff_next = key_diff_reg;
        stage_next    = stage_reg;
        neg_next      = neg_reg;
        value_next    = value_reg;
        bad_next      = bad_reg;
        pend_next     = pend_reg;
        rule_next     = rule_reg;
        known_next    = known_reg;
        rem_next      = rem_reg;
        res_valid     = 1'b0;
        res           = '0;
        do_clear      = 1'b0;
        do_restart    = 1'b0;

        if (fire)
        begin
            if (phase_reg == PH_BODY)
            begin
                res_valid = 1'b1;
                res.kind  = KIND_BODY;
                res.data  = b;
                res.last  = rem_le1;
                if (rem_le1)
                begin
                    do_restart = 1'b1;
                end
                else
                begin
                    rem_next = rem_reg - 1'b1;
                end
            end
            else if (b == CHAR_LF)
            begin
                if (bad_reg || (pend_reg != 2'd0))
                begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_ERROR;
                    res.code   = ERR_BAD_UTF8;
                    do_restart = 1'b1;
                end
                else if (ends_reg || fresh_reg)
                begin
                    if (!known_reg)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.code   = ERR_NO_LENGTH;
                        do_restart = 1'b1;
                    end
                    else if (rem_reg == '0)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_EMPTY;
                        res.last   = 1'b1;
                        do_restart = 1'b1;
                    end
                    else
                    begin
                        do_clear   = 1'b1;
                        phase_next = PH_BODY;
                    end
                end
                else if (!colon_reg)
                begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_ERROR;
                    res.code   = ERR_NO_COLON;
                    do_restart = 1'b1;
                end
                else if (!key_diff_reg && (key_pos_reg == KEY_LEN))
                begin
                    if (len_bad)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.code   = ERR_BAD_LENGTH;
                        do_restart = 1'b1;
                    end
                    else
                    begin
                        known_next = 1'b1;
                        rem_next   = value_reg;
                        do_clear   = 1'b1;
                    end
                end
                else
                begin
                    do_clear = 1'b1;
                end
            end
            else
            begin
                // utf-8 check of the header line
                if (!bad_reg)
                begin
                    if (pend_reg != 2'd0)
                    begin
                        if ((b < lo) || (b > hi))
                        begin
                            bad_next  = 1'b1;
                            pend_next = 2'd0;
                        end
                        else
                        begin
                            rule_next = RULE_ANY;
                            pend_next = pend_reg - 2'd1;
                        end
                    end
                    else if ((b == 8'h00) || ((b >= 8'h80) && (b <= 8'hC1)) || (b >= 8'hF5))
                    begin
                        bad_next = 1'b1;
                    end
                    else if ((b >= 8'hC2) && (b <= 8'hDF))
                    begin
                        pend_next = 2'd1;
                    end
                    else if ((b >= 8'hE0) && (b <= 8'hEF))
                    begin
                        pend_next = 2'd2;
                        rule_next = (b == 8'hE0) ? RULE_A0_BF :
                                    (b == 8'hED) ? RULE_80_9F : RULE_ANY;
                    end
                    else if (b >= 8'hF0)
                    begin
                        pend_next = 2'd3;
                        rule_next = (b == 8'hF0) ? RULE_90_BF :
                                    (b == 8'hF4) ? RULE_80_8F : RULE_ANY;
                    end
                end

                if (fresh_reg && (b == CHAR_CR))
                begin
                    ends_next = 1'b1;
                end
                fresh_next = 1'b0;

                if (colon_reg)
                begin
                    if ((stage_reg == STG_WS) && is_space)
                    begin
                        stage_next = STG_WS;
                    end
                    else if ((stage_reg == STG_WS) &&
                             ((b == CHAR_PLUS) || (b == CHAR_MINUS)))
                    begin
                        neg_next   = (b == CHAR_MINUS);
                        stage_next = STG_SIGN;
                    end
                    else if (stage_reg != STG_DONE)
                    begin
                        if (!is_digit)
                        begin
                            stage_next = STG_DONE;
                        end
                        else
                        begin
                            stage_next = STG_DIGITS;
                            value_next = acc_sat ? '1 : acc[LENGTH_BITS-1:0];
                        end
                    end
                end
                else if (b == CHAR_COLON)
                begin
                    colon_next = 1'b1;
                end
                else
                begin
                    if ((key_pos_reg >= KEY_LEN) || (key_char(key_pos_reg) != lower_b))
                    begin
                        key_diff_next = 1'b1;
                    end
                    if (key_pos_reg < KEY_POS_MAX)
                    begin
                        key_pos_next = key_pos_reg + 4'd1;
                    end
                end
            end
        end

        if (do_clear || do_restart)
        begin
            fresh_next    = 1'b1;
            ends_next     = 1'b0;
            colon_next    = 1'b0;
            key_pos_next  = 4'd0;
            key_diff_next = 1'b0;
            stage_next    = STG_WS;
            neg_next      = 1'b0;
            value_next    = '0;
            bad_next      = 1'b0;
            pend_next     = 2'd0;
            rule_next     = RULE_ANY;
        end
        if (do_restart)
        begin
            phase_next = PH_HEADER;
            known_next = 1'b0;
            rem_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            fresh_reg    <= 1'b1;
            ends_reg     <= 1'b0;
            colon_reg    <= 1'b0;
            key_pos_reg  <= 4'd0;
            key_diff_reg <= 1'b0;
            stage_reg    <= STG_WS;
            neg_reg      <= 1'b0;
            value_reg    <= '0;
            bad_reg      <= 1'b0;
            pend_reg     <= 2'd0;
            rule_reg     <= RULE_ANY;
            known_reg    <= 1'b0;
            rem_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fresh_reg    <= fresh_next;
            ends_reg     <= ends_next;
            colon_reg    <= colon_next;
            key_pos_reg  <= key_pos_next;
            key_diff_reg <= key_diff_next;
            stage_reg    <= stage_next;
            neg_reg      <= neg_next;
            value_reg    <= value_next;
            bad_reg      <= bad_next;
            pend_reg     <= pend_next;
            rule_reg     <= rule_next;
            known_reg    <= known_next;
            rem_reg      <= rem_next;
        end
    end

endmodule

>>> sv/cldf_out_stage.sv
`timescale 1ns / 1ps

module cldf_out_stage
    import cldf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         res_valid,
    input  cldf_result_t res,
    output logic         can_load,
    output logic         out_valid,
    input  logic         out_ready,
    output cldf_result_t out_res
);

    logic         valid_reg;
    cldf_result_t res_reg;

    // free when empty or the waiting transaction leaves this cycle
    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> sv/content_length_message_deframer.sv
`timescale 1ns / 1ps
// Content-Length deframer: takes a byte stream of header lines and a body and
// hands out the body bytes, an empty-message marker or a framing error.
// in channel (in_valid/in_ready/in_byte): one stream byte per transaction.
// out channel (out_valid/out_ready + result fields): at most one result per
// input byte, in stream order; header bytes that end nothing give none.
// cfg channel (cfg_valid/cfg_ready/max_body_bytes): always ready; the user
// must write it only while the block is idle; the block does not enforce this.
// Path: an accepted byte waits in the input register and is decoded into the
// output register, which takes it only when it is empty or being read out.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single decode step between the input register and the output register.
// Reset: max_body_bytes returns to 16 MiB, header parsing starts afresh with
// no length known, both registers are emptied.
// Receiver stall: the output register holds its result, decoding halts, the
// input register keeps one more byte and in_ready then drops.
module content_length_message_deframer
    import cldf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        result_kind,
    output logic [7:0]        body_byte,
    output logic              last_of_message,
    output logic [1:0]        error_code,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MAXB_W-1:0] max_body_bytes
);

    logic [MAXB_W-1:0] max_body_reg;
    logic              held_valid;
    logic [7:0]        held_byte;
    logic              can_load;
    logic              proc_fire;
    logic              res_valid;
    cldf_result_t      res;
    cldf_result_t      out_res;

    assign cfg_ready = 1'b1;
    assign proc_fire = held_valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg <= MAXB_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_body_reg <= max_body_bytes;
        end
    end

    cldf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .take       (proc_fire),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    cldf_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .b         (held_byte),
        .max_body  (max_body_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    cldf_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid && proc_fire),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign result_kind     = out_res.kind;
    assign body_byte       = out_res.data;
    assign last_of_message = out_res.last;
    assign error_code      = out_res.code;

`ifndef SYNTHESIS
    // a held byte is never dropped while the output side is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && !proc_fire |=> held_valid)
        else $error("held input byte lost while decode stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == KIND_BODY) || (result_kind == KIND_EMPTY) ||
                      (result_kind == KIND_ERROR))
        else $error("unknown result kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind != KIND_ERROR) |-> (error_code == ERR_NO_COLON))
        else $error("error code set on a non-error result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_EMPTY) |-> last_of_message)
        else $error("empty-message marker without last");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cldf_pkg::*;

    typedef enum logic [1:0] {NUM_WS, NUM_SIGN, NUM_DIGITS, NUM_DONE} num_stage_t;
    typedef enum logic [2:0] {U8_ANY, U8_A0_BF, U8_80_9F, U8_90_BF, U8_80_8F} u8_rule_t;

    localparam logic [63:0]      LEN_SAT = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
    localparam logic [0:13][7:0] CL_KEY  = "content-length";
    localparam int               RANDOM_BYTES = 400;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        in_byte;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        result_kind;
    logic [7:0]        body_byte;
    logic              last_of_message;
    logic [1:0]        error_code;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [MAXB_W-1:0] max_body_bytes;

    content_length_message_deframer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .body_byte       (body_byte),
        .last_of_message (last_of_message),
        .error_code      (error_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .max_body_bytes  (max_body_bytes)
    );

    // deframer model state
    logic              in_body;
    logic              ln_fresh;
    logic              ln_ends;
    logic              ln_colon;
    logic [3:0]        ln_key_pos;
    logic              ln_key_bad;
    num_stage_t        ln_stage;
    logic              ln_neg;
    logic [63:0]       ln_value;
    logic              ln_utf8_bad;
    logic [1:0]        u8_pending;
    u8_rule_t          u8_rule;
    logic              len_known;
    logic [63:0]       body_left;
    logic [MAXB_W-1:0] max_len;

    cldf_result_t      deframed_queue[$];

    logic              src_idle_on;
    logic              sink_idle_on;
    int                fail_count;
    int                bytes_sent;
    int                n_body;
    int                n_empty;
    int                n_error;
    int                cfg_writes;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic clear_line();
        ln_fresh    = 1'b1;
        ln_ends     = 1'b0;
        ln_colon    = 1'b0;
        ln_key_pos  = '0;
        ln_key_bad  = 1'b0;
        ln_stage    = NUM_WS;
        ln_neg      = 1'b0;
        ln_value    = '0;
        ln_utf8_bad = 1'b0;
        u8_pending  = '0;
        u8_rule     = U8_ANY;
    endtask

    task automatic restart_frame();
        clear_line();
        in_body   = 1'b0;
        len_known = 1'b0;
        body_left = '0;
    endtask

    // works out the result (if any) of one accepted stream byte
    task automatic deframe_byte(input logic [7:0] b);
        cldf_result_t r;
        logic         emit;
        logic         hdr_done;
        logic         is_len_key;
        logic [7:0]   lc;
        logic [7:0]   lo;
        logic [7:0]   hi;
        logic [63:0]  d;
        r    = '0;
        emit = 1'b0;
        if (in_body)
        begin
            emit   = 1'b1;
            r.kind = KIND_BODY;
            r.data = b;
            r.last = (body_left <= 64'd1);
            if (r.last)
                restart_frame();
            else
                body_left = body_left - 64'd1;
        end
        else if (b == CHAR_LF)
        begin
            emit       = 1'b1;
            hdr_done   = ln_ends || ln_fresh;
            is_len_key = !ln_key_bad && ln_key_pos == KEY_LEN;
            if (ln_utf8_bad || u8_pending != 0)
            begin
                r.kind = KIND_ERROR;
                r.code = ERR_BAD_UTF8;
            end
            else if (hdr_done)
            begin
                if (!len_known)
                begin
                    r.kind = KIND_ERROR;
                    r.code = ERR_NO_LENGTH;
                end
                else if (body_left == 0)
                begin
                    r.kind = KIND_EMPTY;
                    r.last = 1'b1;
                end
                else
                    emit = 1'b0;
            end
            else if (!ln_colon)
            begin
                r.kind = KIND_ERROR;
                r.code = ERR_NO_COLON;
            end
            else if (is_len_key && (ln_value == LEN_SAT || (ln_neg && ln_value != 0) ||
                                    ln_value > 64'(max_len)))
            begin
                r.kind = KIND_ERROR;
                r.code = ERR_BAD_LENGTH;
            end
            else
            begin
                emit = 1'b0;
                if (is_len_key)
                begin
                    len_known = 1'b1;
                    body_left = ln_value;
                end
            end
            if (emit)
                restart_frame();
            else
            begin
                clear_line();
                if (hdr_done)
                    in_body = 1'b1;
            end
        end
        else
        begin
            if (!ln_utf8_bad)
            begin
                if (u8_pending != 0)
                begin
                    lo = 8'h80;
                    hi = 8'hBF;
                    case (u8_rule)
                        U8_A0_BF: lo = 8'hA0;
                        U8_80_9F: hi = 8'h9F;
                        U8_90_BF: lo = 8'h90;
                        U8_80_8F: hi = 8'h8F;
                        default: ;
                    endcase
                    if (b < lo || b > hi)
                    begin
                        ln_utf8_bad = 1'b1;
                        u8_pending  = '0;
                    end
                    else
                    begin
                        u8_rule    = U8_ANY;
                        u8_pending = u8_pending - 2'd1;
                    end
                end
                else if (b == 8'h00 || (b >= 8'h80 && b <= 8'hC1) || b >= 8'hF5)
                    ln_utf8_bad = 1'b1;
                else if (b >= 8'hC2 && b <= 8'hDF)
                    u8_pending = 2'd1;
                else if (b >= 8'hE0 && b <= 8'hEF)
                begin
                    u8_pending = 2'd2;
                    u8_rule = (b == 8'hE0) ? U8_A0_BF : (b == 8'hED) ? U8_80_9F : U8_ANY;
                end
                else if (b >= 8'hF0)
                begin
                    u8_pending = 2'd3;
                    u8_rule = (b == 8'hF0) ? U8_90_BF : (b == 8'hF4) ? U8_80_8F : U8_ANY;
                end
            end
            if (ln_fresh && b == CHAR_CR)
                ln_ends = 1'b1;
            ln_fresh = 1'b0;

            if (ln_colon)
            begin
                if (ln_stage == NUM_WS && (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF ||
                                           b == CHAR_VT || b == CHAR_FF || b == CHAR_CR))
                    ;
                else if (ln_stage == NUM_WS && (b == CHAR_PLUS || b == CHAR_MINUS))
                begin
                    ln_neg   = (b == CHAR_MINUS);
                    ln_stage = NUM_SIGN;
                end
                else if (ln_stage == NUM_DONE)
                    ;
                else if (b < CHAR_ZERO || b > CHAR_NINE)
                    ln_stage = NUM_DONE;
                else
                begin
                    ln_stage = NUM_DIGITS;
                    d = 64'(b - CHAR_ZERO);
                    // saturates at all ones
                    if (ln_value > (LEN_SAT - d) / 64'd10)
                        ln_value = LEN_SAT;
                    else
                        ln_value = ln_value * 64'd10 + d;
                end
            end
            else if (b == CHAR_COLON)
                ln_colon = 1'b1;
            else
            begin
                lc = (b >= CHAR_UP_A && b <= CHAR_UP_Z) ? b + CASE_DIFF : b;
                if (ln_key_pos >= KEY_LEN || CL_KEY[ln_key_pos] != lc)
                    ln_key_bad = 1'b1;
                if (ln_key_pos < KEY_POS_MAX)
                    ln_key_pos = ln_key_pos + 4'd1;
            end
        end
        if (emit)
            deframed_queue.push_back(r);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        cldf_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (deframed_queue.size() == 0)
            begin
                $error("unexpected result: kind %0d byte %0h", result_kind, body_byte);
                fail_count++;
            end
            else
            begin
                want = deframed_queue.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                    fail_count++;
                end
                if (body_byte !== want.data)
                begin
                    $error("body_byte: expected %0h, got %0h", want.data, body_byte);
                    fail_count++;
                end
                if (last_of_message !== want.last)
                begin
                    $error("last_of_message: expected %0d, got %0d", want.last,
                           last_of_message);
                    fail_count++;
                end
                if (error_code !== want.code)
                begin
                    $error("error_code: expected %0d, got %0d", want.code, error_code);
                    fail_count++;
                end
                case (want.kind)
                    KIND_BODY:  n_body++;
                    KIND_EMPTY: n_empty++;
                    default:    n_error++;
                endcase
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (sink_idle_on && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (src_idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // sender holds off until every awaited result is out and the pipe is empty
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (deframed_queue.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_max_body(input logic [MAXB_W-1:0] v);
        wait_until_drained();
        cfg_valid      <= 1'b1;
        max_body_bytes <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len = v;
        cfg_writes++;
    endtask

    function automatic logic [7:0] rand_text_byte();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic test_default_limit();
        send_text("content-length:16777217\n");
        send_text("Content-Length:16777216\nbogus\n");
    endtask

    task automatic test_header_errors();
        send_text("\n");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_text("abc\n");
        send_text("Content-Lengthx:1\n\n");
        // NUL, out-of-range lead, overlong, surrogate, above U+10FFFF, cut sequence
        send_byte(8'h00);
        send_byte(CHAR_LF);
        send_byte(8'hFF);
        send_byte(CHAR_LF);
        send_byte(8'hC0);
        send_byte(8'hAF);
        send_byte(CHAR_LF);
        send_byte(8'hE0);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(CHAR_LF);
        send_byte(8'hED);
        send_byte(8'hA0);
        send_byte(8'h80);
        send_byte(CHAR_LF);
        send_byte(8'hF4);
        send_byte(8'h90);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(CHAR_LF);
        send_text("k:");
        send_byte(8'hC3);
        send_byte(CHAR_LF);
        // well-formed multibyte text passes
        send_text("k:");
        send_byte(8'hC3);
        send_byte(8'hA9);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'hAC);
        send_byte(8'hF4);
        send_byte(8'h8F);
        send_byte(8'hBF);
        send_byte(8'hBF);
        send_text("\n\n");
    endtask

    task automatic test_length_forms();
        send_text("CONTENT-length:2\n\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("Content-Length:0\n\n");
        send_text("Content-Length: -0\n");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_text("Content-Length:-1\n");
        send_text("Content-Length:\n\n");
        send_text("Content-Length:+\n\n");
        send_text("Content-Length:99999999999\n");
        // later length line wins
        send_text("Content-Length:7\nContent-Length:1\n\n\n");
        send_text("Content-Length:");
        send_byte(CHAR_VT);
        send_byte(CHAR_FF);
        send_byte(CHAR_TAB);
        send_text(" 3x9\n\na:b");
        send_text("Content-Lengt:1\n\n");
    endtask

    task automatic test_limit_extremes();
        write_max_body('0);
        send_text("Content-Length:1\n");
        send_text("Content-Length:0\n\n");
        write_max_body({MAXB_W{1'b1}});
        send_text("Content-Length:2147483647\nq\n");
        send_text("Content-Length:2147483648\n");
        send_text("Content-Length:4294967295\n");
        write_max_body(MAXB_W'(1));
        send_text("Content-Length:1\n\nA");
        send_text("Content-Length:2\n");
    endtask

    task automatic send_length_line();
        logic [7:0]  c;
        logic [63:0] v;
        int          shape;
        logic        drop_last;
        drop_last = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < 14; i++)
        begin
            c = CL_KEY[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
                c = c - CASE_DIFF;
            if (!(drop_last && i == 13))
                send_byte(c);
        end
        if ($urandom_range(0, 19) == 0)
            send_byte(rand_text_byte());
        send_byte(CHAR_COLON);
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 5))
                0:       send_byte(CHAR_TAB);
                1:       send_byte(CHAR_VT);
                2:       send_byte(CHAR_FF);
                3:       send_byte(CHAR_CR);
                default: send_byte(CHAR_SPACE);
            endcase
        end
        shape = $urandom_range(0, 19);
        if (shape == 0)
            send_byte(CHAR_MINUS);
        else if (shape == 1)
            send_byte(CHAR_PLUS);
        shape = $urandom_range(0, 19);
        if (shape <= 13)
        begin
            v = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 150)) :
                                              64'($urandom_range(0, 24));
            send_text($sformatf("%0d", v));
        end
        else if (shape <= 15)
        begin
            v = 64'(max_len) + 64'($urandom_range(1, 3));
            send_text($sformatf("%0d", v));
        end
        else if (shape == 16)
        begin
            v = (max_len <= 150) ? 64'(max_len) : 64'd5;
            send_text($sformatf("%0d", v));
        end
        else if (shape == 17)
        begin
            repeat ($urandom_range(1, 3)) send_byte(CHAR_ZERO);
            v = 64'($urandom_range(0, 24));
            send_text($sformatf("%0d", v));
        end
        else if (shape == 18)
        begin
            // well past the length width
            send_byte(CHAR_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(10, 20)) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 6) == 0)
            send_byte(rand_text_byte());
        send_byte(CHAR_LF);
    endtask

    task automatic send_other_header();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 3))
                0:       send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
                1:       send_byte(CHAR_UP_A + 8'($urandom_range(0, 25)));
                2:       send_byte(CHAR_MINUS);
                default: send_byte(8'h61 + 8'($urandom_range(0, 25)));
            endcase
        end
        send_byte(CHAR_COLON);
        repeat ($urandom_range(0, 10))
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    send_byte(8'($urandom_range(8'hC2, 8'hDF)));
                    send_byte(8'($urandom_range(8'h80, 8'hBF)));
                end
                1:
                begin
                    send_byte(8'($urandom_range(8'hE1, 8'hEC)));
                    repeat (2) send_byte(8'($urandom_range(8'h80, 8'hBF)));
                end
                2:
                begin
                    send_byte(8'hF0);
                    send_byte(8'($urandom_range(8'h90, 8'hBF)));
                    repeat (2) send_byte(8'($urandom_range(8'h80, 8'hBF)));
                end
                default: send_byte(rand_text_byte());
            endcase
        end
        send_byte(CHAR_LF);
    endtask

    task automatic send_noise_line();
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
        send_byte(CHAR_LF);
    endtask

    // headers in random order, usually one length line, then whatever body it asks for
    task automatic send_random_message();
        int n_lines;
        int len_at;
        n_lines = $urandom_range(0, 2);
        len_at  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n_lines) : -1;
        for (int i = 0; i <= n_lines; i++)
        begin
            if (i == len_at)
                send_length_line();
            if (i < n_lines)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_noise_line();
                else
                    send_other_header();
            end
        end
        case ($urandom_range(0, 5))
            0:
            begin
                send_byte(CHAR_CR);
                send_byte(rand_text_byte());
                send_byte(CHAR_LF);
            end
            1, 2:
            begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            default: send_byte(CHAR_LF);
        endcase
        while (in_body)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic();
        int                start;
        int                step;
        logic [MAXB_W-1:0] lim;
        start = bytes_sent;
        step  = 0;
        while (bytes_sent < start + RANDOM_BYTES)
        begin
            case (step % 5)
                0:       lim = MAXB_W'($urandom_range(0, 40));
                1:       lim = {MAXB_W{1'b1}};
                2:       lim = MAXB_W'($urandom);
                3:       lim = '0;
                default: lim = MAXB_RESET;
            endcase
            write_max_body(lim);
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            repeat (6) send_random_message();
            step++;
        end
    endtask

    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        write_max_body(MAXB_W'(64));
        repeat (10) send_random_message();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_byte        <= '0;
        cfg_valid      <= 1'b0;
        max_body_bytes <= '0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        fail_count   = 0;
        bytes_sent   = 0;
        n_body       = 0;
        n_empty      = 0;
        n_error      = 0;
        cfg_writes   = 0;
        restart_frame();
        max_len = MAXB_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_limit();
        test_header_errors();
        test_length_forms();
        test_limit_extremes();
        test_random_traffic();
        test_back_to_back();

        wait_until_drained();
        repeat (4) @(posedge clk);
        $display("%0d stream bytes in; checked %0d body bytes, %0d empty messages, %0d errors",
                 bytes_sent, n_body, n_empty, n_error);
        $display("%0d length limit writes, with idle bursts and back-to-back traffic",
                 cfg_writes);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
